// ===== rtl/core/pbdm_pkg.sv =====
// Package for the push-button debounce and multi-press detector.
// Holds the phase type, register indexes, field widths and reset values.
// No dependencies.
`timescale 1ns / 1ps

package pbdm_pkg;

  // Field and register widths
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned WINDOW_W   = 16;
  localparam int unsigned HOLDOFF_W  = 24;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TARGET  = 2'd2;

  // Register reset values
  localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 16'd20480;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 24'd1000;
  localparam logic [COUNT_W-1:0]   TARGET_RST  = 4'd5;

  // Saturation limits
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_MAX = 24'hFF_FFFF;
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = 4'hF;

  // Debounce machine phase
  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_WAIT_RELEASE = 2'd1,
    PH_HOLDOFF      = 2'd2
  } phase_e;

endpackage

// ===== rtl/core/pushbutton_debounce_multipress.sv =====
// Push-button debounce with multi-press shutdown detection, top level.
// One tick in, one result out, through a single result register.
// Depends on pbdm_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   in       | in_valid_i/in_ready_o  | button_level, pin_is_input, timestamp
//   out      | out_valid_o/out_ready_i| event_valid, event_time, event_total,
//            |                        | shutdown_request
//   cfg      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A tick's result is in the output register on the cycle after the
// transfer, and a new tick is taken in every cycle that in_ready_o is high.
// The input side stalls only while a result waits and out_ready_i is low.
// Reset (rst_ni, async) puts the machine in idle with all counters zero
// and the registers at their default values; no clearing pass.
`timescale 1ns / 1ps

module pushbutton_debounce_multipress (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [pbdm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pbdm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // tick input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              button_level_i,
  input  logic                              pin_is_input_i,
  input  logic [pbdm_pkg::STAMP_W-1:0]      timestamp_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              event_valid_o,
  output logic [pbdm_pkg::STAMP_W-1:0]      event_time_o,
  output logic [pbdm_pkg::TOTAL_W-1:0]      event_total_o,
  output logic                              shutdown_request_o
);

  import pbdm_pkg::*;

  // configuration registers
  logic [WINDOW_W-1:0]  window_ticks_q;
  logic [HOLDOFF_W-1:0] holdoff_ticks_q;
  logic [COUNT_W-1:0]   press_target_q;

  // machine state
  phase_e               phase_q, phase_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [WINDOW_W-1:0]  window_q, window_d;
  logic [HOLDOFF_W-1:0] holdoff_q, holdoff_d;
  logic [TOTAL_W-1:0]   total_q, total_d;

  // result register
  logic                 out_valid_q;
  logic                 ev_q, ev_d;
  logic                 sd_q, sd_d;
  logic [STAMP_W-1:0]   time_q, time_d;

  logic                 in_xfer;
  logic                 reload;
  logic [HOLDOFF_W-1:0] holdoff_inc;
  logic [COUNT_W-1:0]   count_inc;

  // take a tick whenever the result register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // configuration writes; index three is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ticks_q  <= WINDOW_RST;
      holdoff_ticks_q <= HOLDOFF_RST;
      press_target_q  <= TARGET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_TICKS:  window_ticks_q  <= cfg_data_i[WINDOW_W-1:0];
        REG_HOLDOFF_TICKS: holdoff_ticks_q <= cfg_data_i[HOLDOFF_W-1:0];
        REG_PRESS_TARGET:  press_target_q  <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // hold-off counts on every tick outside idle, enabled or not
  always_comb begin
    holdoff_inc = holdoff_q;
    if ((phase_q == PH_WAIT_RELEASE || phase_q == PH_HOLDOFF) &&
        holdoff_q != HOLDOFF_MAX) begin
      holdoff_inc = holdoff_q + 1'b1;
    end
    count_inc = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
  end

  // next state and result for one tick
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    holdoff_d = holdoff_inc;
    total_d   = total_q;
    reload    = 1'b0;
    ev_d      = 1'b0;
    sd_d      = 1'b0;

    if (pin_is_input_i) begin
      case (phase_q)
        PH_WAIT_RELEASE: begin
          if (!button_level_i) phase_d = PH_HOLDOFF;
        end
        PH_HOLDOFF: begin
          if (holdoff_inc >= holdoff_ticks_q) begin
            count_d = count_inc;
            sd_d    = (count_inc >= press_target_q);
            phase_d = PH_IDLE;
          end
        end
        default: begin
          // expired window drops the press count
          if (window_q == '0) count_d = '0;
          if (button_level_i) begin
            reload    = (window_q == '0);
            ev_d      = 1'b1;
            total_d   = total_q + 1'b1;
            holdoff_d = '0;
            phase_d   = PH_WAIT_RELEASE;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      endcase
    end

    // window countdown, stops at zero
    if (reload) begin
      window_d = window_ticks_q;
    end else if (window_q != '0) begin
      window_d = window_q - 1'b1;
    end else begin
      window_d = window_q;
    end

    time_d = ev_d ? timestamp_i : '0;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      count_q   <= '0;
      window_q  <= '0;
      holdoff_q <= '0;
      total_q   <= '0;
    end else if (in_xfer) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      window_q  <= window_d;
      holdoff_q <= holdoff_d;
      total_q   <= total_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ev_q   <= ev_d;
      sd_q   <= sd_d;
      time_q <= time_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign event_valid_o      = ev_q;
  assign event_time_o       = time_q;
  assign event_total_o      = total_q;
  assign shutdown_request_o = sd_q;

endmodule

// ===== rtl/core/pbdm_checker.sv =====
// Port-level checker for pushbutton_debounce_multipress, with its bind.
// Watches the handshakes and result fields over time.
// Depends on pbdm_pkg.
`timescale 1ns / 1ps

module pbdm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            pin_is_input_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            event_valid_o,
  input logic [pbdm_pkg::STAMP_W-1:0]    event_time_o,
  input logic [pbdm_pkg::TOTAL_W-1:0]    event_total_o,
  input logic                            shutdown_request_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_valid_o) &&
      $stable(event_time_o) && $stable(event_total_o) && $stable(shutdown_request_o))
    else $error("stalled result changed");

  // input stalls only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a disabled tick gives a quiet result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !pin_is_input_i |=>
      out_valid_o && !event_valid_o && !shutdown_request_o)
    else $error("disabled tick produced activity");

  // press event and shutdown come from different phases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(event_valid_o && shutdown_request_o))
    else $error("event and shutdown in one result");

  // no event means a zero timestamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |-> event_time_o == '0)
    else $error("timestamp without event");

endmodule

bind pushbutton_debounce_multipress pbdm_checker u_pbdm_checker (.*);
